[src/lmlc_pkg.sv]
// shared types and constants of the layer compositor
package lmlc_pkg;

	localparam int GridW = 16;
	localparam int GridH = 16;
	localparam int MaxBoundary = 64;
	localparam int MaxTrail = 64;
	localparam int MaxThinking = 8;
	localparam int CellW = $clog2(GridW * GridH);
	localparam int NumCells = GridW * GridH;

	// every chain has the length of the longest list
	localparam int ChainDepth = MaxBoundary > MaxTrail ?
		(MaxBoundary > MaxThinking ? MaxBoundary : MaxThinking) :
		(MaxTrail > MaxThinking ? MaxTrail : MaxThinking);
	localparam int IdxW = $clog2(ChainDepth);

	typedef enum logic [3:0] {
		REQ_CLEAR = 4'd0,
		REQ_START_EPISODE = 4'd1,
		REQ_ADD_BOUNDARY = 4'd2,
		REQ_START_DYNAMIC = 4'd3,
		REQ_ADD_TRAIL = 4'd4,
		REQ_START_THINKING = 4'd5,
		REQ_ADD_THINKING = 4'd6,
		REQ_TICK = 4'd7,
		REQ_READ = 4'd8
	} req_t;

	localparam logic CFG_SERPENTINE = 1'b0;
	localparam logic CFG_HALF_PERIOD = 1'b1;

	// one point flowing through the cell chain
	typedef struct packed {
		logic vld;
		logic [CellW-1:0] loc;
		logic [7:0] level;
	} point_t;

	// control from the sequencer to each cell chain
	typedef struct packed {
		logic clr;
		logic push;
		logic scan;
		logic [CellW-1:0] loc;
		logic [7:0] level;
	} chain_ctl_t;

	// match status returned by a chain
	typedef struct packed {
		logic hit;
		logic [7:0] level;
	} chain_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUT
	} state_t;

	localparam logic [7:0] AgentR = 8'd255, AgentG = 8'd255, AgentB = 8'd255;
	localparam logic [7:0] TrailR = 8'd15, TrailG = 8'd0, TrailB = 8'd0;
	localparam logic [7:0] BoundR = 8'd0, BoundG = 8'd20, BoundB = 8'd0;
	localparam logic [7:0] TargetR = 8'd0, TargetG = 8'd0, TargetB = 8'd60;

endpackage

[src/lmlc_cell.sv]
// one storage cell of a point chain: holds a point and passes it on when shifting
module lmlc_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic shift,
	input  lmlc_pkg::point_t prev,
	output lmlc_pkg::point_t pt
);
	logic vld_q;
	logic [lmlc_pkg::CellW-1:0] loc_q;
	logic [7:0] level_q;

	// valid bit resets, payload loads only on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= prev.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			loc_q <= prev.loc;
			level_q <= prev.level;
		end
	end

	always_comb begin
		pt.vld = vld_q;
		pt.loc = loc_q;
		pt.level = level_q;
	end
endmodule

[src/lmlc_chain.sv]
// point list as a rotating chain of cells; a scan rotates it once past the head
module lmlc_chain (
	input  logic clk,
	input  logic arst_n,
	// last cell that the list may fill
	input  logic [lmlc_pkg::IdxW-1:0] last_idx,
	input  lmlc_pkg::chain_ctl_t ctl,
	output logic full,
	output lmlc_pkg::chain_sts_t sts
);
	localparam int Depth = lmlc_pkg::ChainDepth;

	lmlc_pkg::point_t pts [Depth];
	lmlc_pkg::point_t feed [Depth];
	lmlc_pkg::point_t ins;
	logic shift;
	logic head_match;
	logic hit_q;
	logic [7:0] lvl_q;

	// a push inserts at the tail, a scan rotates the head back to the tail
	assign shift = ctl.push | ctl.scan;
	always_comb begin
		ins.vld = 1'b1;
		ins.loc = ctl.loc;
		ins.level = ctl.level;
	end
	assign feed[0] = ctl.push ? ins : pts[Depth-1];

	genvar g;
	generate
		for (g = 0; g < Depth; g++) begin : g_cell
			if (g > 0) begin : g_link
				assign feed[g] = pts[g-1];
			end
			lmlc_cell u_cell (
				.clk(clk), .arst_n(arst_n), .clr(ctl.clr), .shift(shift),
				.prev(feed[g]), .pt(pts[g])
			);
		end
	endgenerate

	// the list is full once its last usable cell holds a point
	assign full = pts[last_idx].vld;

	assign head_match = pts[Depth-1].vld && pts[Depth-1].loc == ctl.loc;

	// head match during a scan; oldest comes first, so a later match overrides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clr || (!ctl.scan && ctl.push)) begin
			hit_q <= hit_q;
		end else if (!ctl.scan) begin
			hit_q <= 1'b0;
		end else if (head_match) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan && head_match) begin
			lvl_q <= pts[Depth-1].level;
		end
	end

	always_comb begin
		sts.hit = hit_q;
		sts.level = lvl_q;
	end
endmodule

[src/led_matrix_layer_compositor.sv]
// top level of the layer compositor: sequencer, registers and three point chains
//
//   channel | dir | handshake       | payload
//   s_axis  | in  | tvalid/tready   | req_type, x, y, level, busy, now_ms, strip_position
//   m_axis  | out | tvalid/tready   | red, green, blue, point_stored, blink_on, redraw
//   cfg     | in  | valid/ready     | index (1 bit), data (16 bits)
//
// items other than an on-strip read are accepted, then their result is held in the output register
// an on-strip read also scans: every chain rotates once past its head (64 steps),
// then a final scan state writes the colour from the head matches into the output register
// arst_n empties all lists, blink phase on, serpentine on, half period 15
// a stalled output holds the result; no new item is taken until it is delivered
module led_matrix_layer_compositor (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [3:0] req_type, [19:4] x_coord, [35:20] y_coord, [43:36] level,
	// [44] serial_busy, [76:45] now_ms, [84:77] strip_position, rest zero
	input  logic [87:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [24] point_stored, [25] blink_on,
	// [26] redraw, rest zero
	output logic [31:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CW = lmlc_pkg::CellW;
	localparam int IW = lmlc_pkg::IdxW;
	localparam int ScanLen = lmlc_pkg::ChainDepth;
	localparam int CntW = $clog2(ScanLen + 1);
	localparam logic [IW-1:0] BndLast = IW'(lmlc_pkg::MaxBoundary - 1);
	localparam logic [IW-1:0] TrlLast = IW'(lmlc_pkg::MaxTrail - 1);
	localparam logic [IW-1:0] ThkLast = IW'(lmlc_pkg::MaxThinking - 1);

	lmlc_pkg::state_t state_q, state_nx;
	logic serp_q;
	logic [15:0] half_q;
	logic blink_q;
	logic [31:0] last_q;
	logic [CW-1:0] target_q, agent_q;
	logic target_vld_q, agent_vld_q;
	logic [CntW-1:0] cnt_q;
	logic [CW-1:0] rcell_q;
	logic rin_q;
	logic [31:0] out_q;

	// input fields
	logic [3:0] req;
	logic signed [15:0] xi, yi;
	logic [7:0] lvl, spos;
	logic busy;
	logic [31:0] now;
	logic on_grid;
	logic [CW-1:0] pcell;
	logic acc;

	assign req = s_axis_tdata[3:0];
	assign xi = s_axis_tdata[19:4];
	assign yi = s_axis_tdata[35:20];
	assign lvl = s_axis_tdata[43:36];
	assign busy = s_axis_tdata[44];
	assign now = s_axis_tdata[76:45];
	assign spos = s_axis_tdata[84:77];
	assign acc = s_axis_tvalid & s_axis_tready;
	assign cfg_ready = 1'b1;

	// grid check and cell index of the item point
	always_comb begin
		on_grid = xi >= 0 && xi < 16'(lmlc_pkg::GridW) &&
			yi >= 0 && yi < 16'(lmlc_pkg::GridH);
		pcell = CW'(yi) * CW'(lmlc_pkg::GridW) + CW'(xi);
	end

	// strip position to grid cell with optional serpentine mirror
	logic [CW-1:0] scell;
	logic [CW-1:0] sx, sy;
	logic sin;
	always_comb begin
		sin = 9'(spos) < 9'(lmlc_pkg::NumCells);
		sy = CW'(spos / lmlc_pkg::GridW);
		sx = CW'(spos % lmlc_pkg::GridW);
		if (serp_q && sy[0]) begin
			sx = CW'(lmlc_pkg::GridW - 1) - sx;
		end
		scell = sy * CW'(lmlc_pkg::GridW) + sx;
	end

	// chain control
	lmlc_pkg::chain_ctl_t bctl, tctl, kctl;
	lmlc_pkg::chain_sts_t bsts, tsts, ksts;
	logic bfull, tfull, kfull;
	logic scanning;
	logic scan_on;
	assign scanning = state_q == lmlc_pkg::ST_SCAN;
	// chains rotate while the scan count is below ScanLen, the last scan cycle collects
	assign scan_on = scanning && cnt_q < CntW'(ScanLen);

	always_comb begin
		bctl = '0; tctl = '0; kctl = '0;
		bctl.loc = scanning ? rcell_q : pcell;
		tctl.loc = bctl.loc; kctl.loc = bctl.loc;
		kctl.level = lvl;
		bctl.level = lvl; tctl.level = lvl;
		bctl.scan = scan_on;
		tctl.scan = scan_on;
		kctl.scan = scan_on;
		if (acc) begin
			unique case (req)
				lmlc_pkg::REQ_CLEAR: begin
					bctl.clr = 1'b1; tctl.clr = 1'b1; kctl.clr = 1'b1;
				end
				lmlc_pkg::REQ_START_EPISODE: bctl.clr = 1'b1;
				lmlc_pkg::REQ_ADD_BOUNDARY: bctl.push = on_grid & ~bfull;
				lmlc_pkg::REQ_START_DYNAMIC: begin
					tctl.clr = 1'b1; kctl.clr = 1'b1;
				end
				lmlc_pkg::REQ_ADD_TRAIL: tctl.push = on_grid & ~tfull;
				lmlc_pkg::REQ_START_THINKING: kctl.clr = 1'b1;
				lmlc_pkg::REQ_ADD_THINKING: kctl.push = on_grid & ~kfull;
				default: ;
			endcase
		end
	end

	lmlc_chain u_bnd (
		.clk(clk), .arst_n(arst_n), .last_idx(BndLast), .ctl(bctl), .full(bfull),
		.sts(bsts));
	lmlc_chain u_trl (
		.clk(clk), .arst_n(arst_n), .last_idx(TrlLast), .ctl(tctl), .full(tfull),
		.sts(tsts));
	lmlc_chain u_thk (
		.clk(clk), .arst_n(arst_n), .last_idx(ThkLast), .ctl(kctl), .full(kfull),
		.sts(ksts));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lmlc_pkg::ST_IDLE:
				if (acc) state_nx = req == lmlc_pkg::REQ_READ && sin ?
					lmlc_pkg::ST_SCAN : lmlc_pkg::ST_OUT;
			lmlc_pkg::ST_SCAN:
				if (cnt_q == CntW'(ScanLen)) state_nx = lmlc_pkg::ST_OUT;
			lmlc_pkg::ST_OUT:
				if (m_axis_tready) state_nx = lmlc_pkg::ST_IDLE;
			default: state_nx = lmlc_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_axis_tready = state_q == lmlc_pkg::ST_IDLE;
		m_axis_tvalid = state_q == lmlc_pkg::ST_OUT;
		m_axis_tdata = out_q;
	end

	// item decode for the blink tick, stored flag and blink phase after the item
	logic toggle, stored, redraw, blink_nx;
	always_comb begin
		toggle = req == lmlc_pkg::REQ_TICK && !busy && (now - last_q) >= 32'(half_q);
		stored = (bctl.push | tctl.push | kctl.push);
		redraw = req == lmlc_pkg::REQ_CLEAR || req == lmlc_pkg::REQ_START_EPISODE ||
			req == lmlc_pkg::REQ_START_DYNAMIC || req == lmlc_pkg::REQ_START_THINKING ||
			stored || toggle;
		if (toggle) begin
			blink_nx = ~blink_q;
		end else if (req == lmlc_pkg::REQ_CLEAR || req == lmlc_pkg::REQ_START_EPISODE) begin
			blink_nx = 1'b1;
		end else begin
			blink_nx = blink_q;
		end
	end

	// composited colour after the scan
	logic [23:0] rgb;
	always_comb begin
		rgb = '0;
		if (rin_q) begin
			priority if (agent_vld_q && agent_q == rcell_q)
				rgb = {lmlc_pkg::AgentB, lmlc_pkg::AgentG, lmlc_pkg::AgentR};
			else if (ksts.hit)
				rgb = {8'd0, ksts.level, ksts.level};
			else if (!blink_q)
				rgb = '0;
			else if (tsts.hit)
				rgb = {lmlc_pkg::TrailB, lmlc_pkg::TrailG, lmlc_pkg::TrailR};
			else if (target_vld_q && target_q == rcell_q)
				rgb = {lmlc_pkg::TargetB, lmlc_pkg::TargetG, lmlc_pkg::TargetR};
			else if (bsts.hit)
				rgb = {lmlc_pkg::BoundB, lmlc_pkg::BoundG, lmlc_pkg::BoundR};
			else
				rgb = '0;
		end
	end

	// control and layer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmlc_pkg::ST_IDLE;
			serp_q <= 1'b1;
			half_q <= 16'd15;
			blink_q <= 1'b1;
			last_q <= '0;
			target_q <= '0; target_vld_q <= 1'b0;
			agent_q <= '0; agent_vld_q <= 1'b0;
			cnt_q <= '0;
			rin_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				unique case (cfg_index)
					lmlc_pkg::CFG_SERPENTINE: serp_q <= cfg_data[0];
					lmlc_pkg::CFG_HALF_PERIOD: half_q <= cfg_data;
					default: ;
				endcase
			end
			cnt_q <= scanning ? cnt_q + CntW'(1) : '0;
			if (acc) begin
				rin_q <= req == lmlc_pkg::REQ_READ && sin;
				unique case (req)
					lmlc_pkg::REQ_CLEAR: begin
						target_vld_q <= 1'b0; agent_vld_q <= 1'b0;
						blink_q <= 1'b1; last_q <= now;
					end
					lmlc_pkg::REQ_START_EPISODE: begin
						target_vld_q <= on_grid; target_q <= pcell;
						blink_q <= 1'b1; last_q <= now;
					end
					lmlc_pkg::REQ_START_DYNAMIC: begin
						agent_vld_q <= on_grid; agent_q <= pcell;
					end
					lmlc_pkg::REQ_TICK:
						if (toggle) begin
							blink_q <= ~blink_q; last_q <= now;
						end
					default: ;
				endcase
			end
		end
	end

	// result register: written at accept, colour filled in at scan end
	always_ff @(posedge clk) begin
		if (acc) begin
			out_q <= {5'd0, redraw, blink_nx, stored, 24'd0};
			rcell_q <= scell;
		end else if (state_q == lmlc_pkg::ST_OUT && !m_axis_tvalid) begin
			out_q <= out_q;
		end
		if (state_q == lmlc_pkg::ST_SCAN && state_nx == lmlc_pkg::ST_OUT) begin
			out_q[23:0] <= rgb;
		end
	end

	// one item in flight: no accept while a result is pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lmlc_pkg::ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
	// a scan ends within its fixed length
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		scanning |-> cnt_q <= CntW'(ScanLen)) else $error("scan overrun");
	// blink only changes on an accepted item
	a_blink_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(acc) |-> $stable(blink_q)) else $error("blink changed without item");
endmodule
